### rtl/core/ecd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ecd_pkg;

  // pipeline depth, accept to result register
  localparam int NUM_STAGES = 15;

  // zone offset after reset: -25200 s
  localparam logic signed [16:0] ZONE_RESET = -17'sd25200;

  // seconds per day split as 128 * 675, reciprocal for the upper part
  localparam int DAY_HI_DIV   = 675;
  localparam int DAY_HI_RCP   = 49710;   // floor(2^25 / 675)
  localparam int DAY_HI_SHIFT = 25;

  localparam int HOUR_DIV   = 3600;
  localparam int HOUR_RCP   = 36;        // floor(2^17 / 3600)
  localparam int HOUR_SHIFT = 17;

  localparam int MIN_DIV   = 60;
  localparam int MIN_RCP   = 68;         // floor(2^12 / 60)
  localparam int MIN_SHIFT = 12;

  localparam int WEEK_DIV   = 7;
  localparam int WEEK_RCP   = 9362;      // floor(2^16 / 7)
  localparam int WEEK_SHIFT = 16;
  localparam int WEEK_EPOCH = 4;         // 1970-01-01 was a thursday

  // civil day count shift and era bounds (era 4 starts 1600-03-01)
  localparam int CIVIL_SHIFT  = 719468;
  localparam int ERA4_START   = 584388;  // 4 * 146097
  localparam int ERA5_START   = 730485;  // 5 * 146097
  localparam int ERA_LAST_DOE = 146096;
  localparam int YEAR_ERA4    = 1600;
  localparam int YEAR_ERA5    = 2000;

  localparam int QUAD_DIV = 1460;
  localparam int QUAD_RCP = 179;         // floor(2^18 / 1460)
  localparam int CENT_DIV = 36524;
  localparam int CENT_RCP = 7;           // floor(2^18 / 36524)
  localparam int YEAR_DIV = 365;
  localparam int YEAR_RCP = 718;         // floor(2^18 / 365)
  localparam int DOE_SHIFT = 18;

  localparam int MP_DIV   = 153;
  localparam int MP_RCP   = 13;          // floor(2^11 / 153)
  localparam int MP_SHIFT = 11;

  // one slot of the conversion pipeline
  typedef struct packed {
    logic [31:0] t;
    logic [15:0] q_est;
    logic [15:0] days;
    logic [16:0] sod;
    logic [4:0]  h_est;
    logic [15:0] n7;
    logic [12:0] w_est;
    logic [17:0] doe;
    logic        era5;
    logic [4:0]  hour;
    logic [11:0] ms;
    logic [2:0]  wday;
    logic [6:0]  a_est;
    logic [2:0]  b_est;
    logic [6:0]  a_cnt;
    logic [2:0]  b_cnt;
    logic [5:0]  m_est;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [17:0] num;
    logic [8:0]  y_est;
    logic [8:0]  yoe;
    logic [8:0]  doy;
    logic [10:0] mp_n;
    logic [3:0]  mp_est;
    logic [3:0]  mp;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [11:0] year;
    logic        leap;
    logic [8:0]  yday;
  } stage_t;

  // first day of each march-based month, (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] res;
    unique case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // days before a january-based month in a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] res;
    unique case (m)
      4'd1:    res = 9'd0;
      4'd2:    res = 9'd31;
      4'd3:    res = 9'd59;
      4'd4:    res = 9'd90;
      4'd5:    res = 9'd120;
      4'd6:    res = 9'd151;
      4'd7:    res = 9'd181;
      4'd8:    res = 9'd212;
      4'd9:    res = 9'd243;
      4'd10:   res = 9'd273;
      4'd11:   res = 9'd304;
      4'd12:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/epoch_to_calendar_date.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                                   handshake
// request   in_epoch_seconds                        start, busy
// result    out_second .. out_leap_year             out_valid (one-cycle strobe)
// config    cfg_wdata (zone offset, signed 17 bit)  cfg_we
//
// one request per cycle; busy stays low, the pipeline never holds off
// a result strobes when its request leaves the last of the chain of
// reciprocal-multiply and correction stages of the day-to-date conversion
// rst_n is synchronous: clears the valid bits and loads the offset -25200
// the receiver cannot stall, so results leave the last stage as they arrive

module epoch_to_calendar_date (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_epoch_seconds,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata,
  output logic             out_valid,
  output logic [5:0]       out_second,
  output logic [5:0]       out_minute,
  output logic [4:0]       out_hour,
  output logic [2:0]       out_weekday,
  output logic [4:0]       out_day_of_month,
  output logic [3:0]       out_month,
  output logic [11:0]      out_year,
  output logic [8:0]       out_ordinal_day,
  output logic             out_leap_year
);
  import ecd_pkg::*;

  logic signed [16:0]    offset_r;
  logic                  in_accept;
  logic [NUM_STAGES-1:0] valid_r;
  stage_t                stage_r   [NUM_STAGES];
  stage_t                stage_nxt [NUM_STAGES];

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // zone offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= ZONE_RESET;
    end else if (cfg_we) begin
      offset_r <= cfg_wdata;
    end
  end

  // valid bits travel with the slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[NUM_STAGES-2:0], in_accept};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      stage_r[k] <= stage_nxt[k];
    end
  end

  // stage logic
  always_comb begin
    logic [40:0] day_mul;
    logic [25:0] day_prod;
    logic [10:0] day_rem;
    logic [9:0]  sec_hi;
    logic [22:0] hour_mul;
    logic [29:0] week_mul;
    logic [19:0] civil;
    logic [16:0] hour_prod;
    logic [16:0] hour_rem;
    logic [15:0] week_prod;
    logic [3:0]  week_rem;
    logic [25:0] quad_mul;
    logic [20:0] cent_mul;
    logic [18:0] min_mul;
    logic [17:0] quad_prod;
    logic [17:0] cent_prod;
    logic [11:0] min_prod;
    logic [6:0]  min_rem;
    logic [27:0] year_mul;
    logic [17:0] year_prod;
    logic [1:0]  cent_cnt;
    logic [17:0] year_base;
    logic [14:0] mp_mul;
    logic [10:0] mp_prod;
    logic [8:0]  yy;

    for (int k = 1; k < NUM_STAGES; k++) begin
      stage_nxt[k] = stage_r[k-1];
    end

    // shift by the zone offset, wraps at 32 bits
    stage_nxt[0]   = '0;
    stage_nxt[0].t = in_epoch_seconds + {{15{offset_r[16]}}, offset_r};

    // day count estimate from the upper 25 bits
    day_mul = 41'(stage_r[0].t[31:7]) * 41'(DAY_HI_RCP);
    stage_nxt[1].q_est = 16'(day_mul >> DAY_HI_SHIFT);

    // day count correction, second of day
    day_prod = 26'(stage_r[1].q_est) * 26'(DAY_HI_DIV);
    day_rem  = 11'(26'(stage_r[1].t[31:7]) - day_prod);
    if (day_rem >= 11'(DAY_HI_DIV)) begin
      stage_nxt[2].days = stage_r[1].q_est + 16'd1;
      sec_hi            = 10'(day_rem - 11'(DAY_HI_DIV));
    end else begin
      stage_nxt[2].days = stage_r[1].q_est;
      sec_hi            = day_rem[9:0];
    end
    stage_nxt[2].sod = {sec_hi, stage_r[1].t[6:0]};

    // hour and weekday estimates, day of era
    hour_mul = 23'(stage_r[2].sod) * 23'(HOUR_RCP);
    stage_nxt[3].h_est = 5'(hour_mul >> HOUR_SHIFT);
    stage_nxt[3].n7    = stage_r[2].days + 16'(WEEK_EPOCH);
    week_mul = 30'(stage_nxt[3].n7) * 30'(WEEK_RCP);
    stage_nxt[3].w_est = 13'(week_mul >> WEEK_SHIFT);
    civil = 20'(stage_r[2].days) + 20'(CIVIL_SHIFT);
    stage_nxt[3].era5 = civil >= 20'(ERA5_START);
    stage_nxt[3].doe  = stage_nxt[3].era5 ? 18'(civil - 20'(ERA5_START))
                                          : 18'(civil - 20'(ERA4_START));

    // hour and weekday corrections, 4-year and century estimates
    hour_prod = 17'(stage_r[3].h_est) * 17'(HOUR_DIV);
    hour_rem  = stage_r[3].sod - hour_prod;
    if (hour_rem >= 17'(HOUR_DIV)) begin
      stage_nxt[4].hour = stage_r[3].h_est + 5'd1;
      stage_nxt[4].ms   = 12'(hour_rem - 17'(HOUR_DIV));
    end else begin
      stage_nxt[4].hour = stage_r[3].h_est;
      stage_nxt[4].ms   = 12'(hour_rem);
    end
    week_prod = 16'(stage_r[3].w_est) * 16'(WEEK_DIV);
    week_rem  = 4'(stage_r[3].n7 - week_prod);
    stage_nxt[4].wday = (week_rem >= 4'(WEEK_DIV)) ? 3'(week_rem - 4'(WEEK_DIV))
                                                   : 3'(week_rem);
    quad_mul = 26'(stage_r[3].doe) * 26'(QUAD_RCP);
    stage_nxt[4].a_est = 7'(quad_mul >> DOE_SHIFT);
    cent_mul = 21'(stage_r[3].doe) * 21'(CENT_RCP);
    stage_nxt[4].b_est = 3'(cent_mul >> DOE_SHIFT);

    // minute estimate, 4-year and century corrections
    min_mul = 19'(stage_r[4].ms) * 19'(MIN_RCP);
    stage_nxt[5].m_est = 6'(min_mul >> MIN_SHIFT);
    quad_prod = 18'(stage_r[4].a_est) * 18'(QUAD_DIV);
    stage_nxt[5].a_cnt = ((stage_r[4].doe - quad_prod) >= 18'(QUAD_DIV))
                         ? stage_r[4].a_est + 7'd1 : stage_r[4].a_est;
    cent_prod = 18'(stage_r[4].b_est) * 18'(CENT_DIV);
    stage_nxt[5].b_cnt = ((stage_r[4].doe - cent_prod) >= 18'(CENT_DIV))
                         ? stage_r[4].b_est + 3'd1 : stage_r[4].b_est;

    // minute correction, leap-free day count of the era
    min_prod = 12'(stage_r[5].m_est) * 12'(MIN_DIV);
    min_rem  = 7'(stage_r[5].ms - min_prod);
    if (min_rem >= 7'(MIN_DIV)) begin
      stage_nxt[6].minute = stage_r[5].m_est + 6'd1;
      stage_nxt[6].second = 6'(min_rem - 7'(MIN_DIV));
    end else begin
      stage_nxt[6].minute = stage_r[5].m_est;
      stage_nxt[6].second = 6'(min_rem);
    end
    stage_nxt[6].num = stage_r[5].doe - 18'(stage_r[5].a_cnt) + 18'(stage_r[5].b_cnt)
                       - 18'(stage_r[5].doe == 18'(ERA_LAST_DOE));

    // year of era estimate
    year_mul = 28'(stage_r[6].num) * 28'(YEAR_RCP);
    stage_nxt[7].y_est = 9'(year_mul >> DOE_SHIFT);

    // year of era correction
    year_prod = 18'(stage_r[7].y_est) * 18'(YEAR_DIV);
    stage_nxt[8].yoe = ((stage_r[7].num - year_prod) >= 18'(YEAR_DIV))
                       ? stage_r[7].y_est + 9'd1 : stage_r[7].y_est;

    // day of the march-based year
    priority if (stage_r[8].yoe >= 9'd300) cent_cnt = 2'd3;
    else if (stage_r[8].yoe >= 9'd200)     cent_cnt = 2'd2;
    else if (stage_r[8].yoe >= 9'd100)     cent_cnt = 2'd1;
    else                                   cent_cnt = 2'd0;
    year_base = 18'(stage_r[8].yoe) * 18'(YEAR_DIV) + 18'(stage_r[8].yoe[8:2])
                - 18'(cent_cnt);
    stage_nxt[9].doy = 9'(stage_r[8].doe - year_base);

    // month numerator
    stage_nxt[10].mp_n = 11'(stage_r[9].doy) * 11'd5 + 11'd2;

    // month estimate
    mp_mul = 15'(stage_r[10].mp_n) * 15'(MP_RCP);
    stage_nxt[11].mp_est = 4'(mp_mul >> MP_SHIFT);

    // month correction
    mp_prod = 11'(stage_r[11].mp_est) * 11'(MP_DIV);
    stage_nxt[12].mp = ((stage_r[11].mp_n - mp_prod) >= 11'(MP_DIV))
                       ? stage_r[11].mp_est + 4'd1 : stage_r[11].mp_est;

    // day, month, year and leap flag
    stage_nxt[13].mday  = 5'(stage_r[12].doy - month_start(stage_r[12].mp) + 9'd1);
    stage_nxt[13].month = (stage_r[12].mp < 4'd10) ? stage_r[12].mp + 4'd3
                                                   : stage_r[12].mp - 4'd9;
    yy = stage_r[12].yoe + 9'(stage_r[12].mp >= 4'd10);
    stage_nxt[13].year = (stage_r[12].era5 ? 12'(YEAR_ERA5) : 12'(YEAR_ERA4)) + 12'(yy);
    stage_nxt[13].leap = (yy[1:0] == 2'd0) && (yy != 9'd100) && (yy != 9'd200)
                         && (yy != 9'd300);

    // day of january-based year
    stage_nxt[14].yday = days_before(stage_r[13].month) + 9'(stage_r[13].mday)
                         + 9'(stage_r[13].leap && (stage_r[13].month > 4'd2));
  end

  // result ports
  assign out_valid        = valid_r[NUM_STAGES-1];
  assign out_second       = stage_r[NUM_STAGES-1].second;
  assign out_minute       = stage_r[NUM_STAGES-1].minute;
  assign out_hour         = stage_r[NUM_STAGES-1].hour;
  assign out_weekday      = stage_r[NUM_STAGES-1].wday;
  assign out_day_of_month = stage_r[NUM_STAGES-1].mday;
  assign out_month        = stage_r[NUM_STAGES-1].month;
  assign out_year         = stage_r[NUM_STAGES-1].year;
  assign out_ordinal_day  = stage_r[NUM_STAGES-1].yday;
  assign out_leap_year    = stage_r[NUM_STAGES-1].leap;

  // every request comes out after the full pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##NUM_STAGES out_valid)
    else $error("request did not produce a result at pipeline depth");

  // time and date fields stay in range
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month != 4'd0) && (out_month <= 4'd12)
                  && (out_day_of_month != 5'd0) && (out_hour <= 5'd23)
                  && (out_minute <= 6'd59) && (out_second <= 6'd59)
                  && (out_weekday <= 3'd6) && (out_ordinal_day != 9'd0))
    else $error("result field out of range");

  // day 366 only in a leap year, and leap years divide by four
  a_leap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_leap_year ? (out_year[1:0] == 2'd0)
                                 : (out_ordinal_day <= 9'd365)))
    else $error("leap flag disagrees with year or day of year");

endmodule

`default_nettype wire

### test/calendar_date_checker.sv
`timescale 1ns / 1ps

module calendar_date_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [31:0] in_epoch_seconds,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata,
  input  wire logic        out_valid,
  input  wire logic [5:0]  out_second,
  input  wire logic [5:0]  out_minute,
  input  wire logic [4:0]  out_hour,
  input  wire logic [2:0]  out_weekday,
  input  wire logic [4:0]  out_day_of_month,
  input  wire logic [3:0]  out_month,
  input  wire logic [11:0] out_year,
  input  wire logic [8:0]  out_ordinal_day,
  input  wire logic        out_leap_year,
  output int               errors,
  output int               pending
);
  import ecd_pkg::*;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned DAYS_PER_ERA = 146097;
  localparam int unsigned MARCH_SHIFT  = 719468;  // 0000-03-01 to 1970-01-01

  typedef struct packed {
    logic [31:0] epoch;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] year;
    logic [8:0]  ordinal_day;
    logic        leap_year;
  } local_date_t;

  local_date_t expected_dates[$];
  logic [16:0] zone_offset = ZONE_RESET;
  int          error_count = 0;

  assign errors = error_count;

  // local calendar date of a timestamp shifted by the zone offset
  function automatic local_date_t to_calendar(input logic [31:0] epoch,
                                              input logic [16:0] offset);
    int unsigned cum_days [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    logic [31:0] local_secs;
    int unsigned days, sod, shifted, era, doe, yoe, yr, doy_mar, mp, mday, mon, yday;
    bit          leap;
    local_date_t r;
    local_secs = epoch + {{15{offset[16]}}, offset};
    days       = local_secs / SECS_PER_DAY;
    sod        = local_secs % SECS_PER_DAY;
    // march-based years inside 400-year eras
    shifted = days + MARCH_SHIFT;
    era     = shifted / DAYS_PER_ERA;
    doe     = shifted - era * DAYS_PER_ERA;
    yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    yr      = yoe + era * 400;
    doy_mar = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp      = (5 * doy_mar + 2) / 153;
    mday    = doy_mar - (153 * mp + 2) / 5 + 1;
    mon     = (mp < 10) ? mp + 3 : mp - 9;
    if (mon <= 2) yr = yr + 1;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    yday = cum_days[mon - 1] + mday + ((leap && mon > 2) ? 1 : 0);
    r.epoch        = epoch;
    r.second       = 6'(sod % 60);
    r.minute       = 6'((sod / 60) % 60);
    r.hour         = 5'(sod / 3600);
    r.weekday      = 3'((days + 4) % 7);
    r.day_of_month = 5'(mday);
    r.month        = 4'(mon);
    r.year         = 12'(yr);
    r.ordinal_day  = 9'(yday);
    r.leap_year    = leap;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] epoch,
                             input int got, input int want);
    if (got != want)
      flag_error($sformatf("epoch %0d %s: got %0d, expected %0d", epoch, name, got, want));
  endtask

  // track requests, zone writes and result strobes
  always @(posedge clk) begin
    local_date_t want;
    if (!rst_n) begin
      zone_offset <= ZONE_RESET;
      expected_dates.delete();
    end else begin
      if (start && !busy)
        expected_dates.push_back(to_calendar(in_epoch_seconds, zone_offset));
      if (cfg_we)
        zone_offset <= cfg_wdata;
      if (out_valid) begin
        if (expected_dates.size() == 0) begin
          flag_error("result with no request pending");
        end else begin
          want = expected_dates.pop_front();
          check_field("second", want.epoch, int'(out_second), int'(want.second));
          check_field("minute", want.epoch, int'(out_minute), int'(want.minute));
          check_field("hour", want.epoch, int'(out_hour), int'(want.hour));
          check_field("weekday", want.epoch, int'(out_weekday), int'(want.weekday));
          check_field("day_of_month", want.epoch, int'(out_day_of_month),
                      int'(want.day_of_month));
          check_field("month", want.epoch, int'(out_month), int'(want.month));
          check_field("year", want.epoch, int'(out_year), int'(want.year));
          check_field("ordinal_day", want.epoch, int'(out_ordinal_day),
                      int'(want.ordinal_day));
          check_field("leap_year", want.epoch, int'(out_leap_year), int'(want.leap_year));
        end
      end
    end
    pending <= expected_dates.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import ecd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 62;

  // wrap edges, plus utc dates shifted by 25200 onto local boundaries at reset offset
  localparam logic [31:0] EDGE_TIMES [15] = '{
    32'd0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'd1,
    32'd25199, 32'd25200, 32'd111599, 32'hAAAAAAAA, 32'h55555555,
    32'd951807600, 32'd951893999, 32'd946709999, 32'd4107567599, 32'd94719599
  };
  localparam logic [16:0] ZONE_SETTINGS [5] = '{
    17'd0, 17'd50400, -17'sd50400, 17'h0FFFF, 17'h10000
  };
  localparam int IDLE_PCT [3] = '{0, 84, 14};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_epoch_seconds = '0;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic [16:0] zone_now = ZONE_RESET;
  int          cycles = 0;

  logic        busy;
  logic        out_valid;
  logic [5:0]  out_second;
  logic [5:0]  out_minute;
  logic [4:0]  out_hour;
  logic [2:0]  out_weekday;
  logic [4:0]  out_day_of_month;
  logic [3:0]  out_month;
  logic [11:0] out_year;
  logic [8:0]  out_ordinal_day;
  logic        out_leap_year;
  int          errors;
  int          pending;

  always #2 clk = ~clk;

  epoch_to_calendar_date dut (.*);
  calendar_date_checker chk (.*);

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // random timestamp, biased toward day, year and wrap boundaries of local time
  function automatic logic [31:0] pick_epoch();
    int unsigned day_picks [5] = '{0, 58, 59, 364, 365};
    int unsigned kind, days, yr;
    logic [31:0] t;
    kind = $urandom_range(99);
    if (kind < 35) begin
      t = $urandom();
    end else if (kind < 55) begin
      days = $urandom_range(49710);
      case ($urandom_range(2))
        0: t = days * 86400;
        1: t = days * 86400 + 86399;
        default: t = days * 86400 + $urandom_range(86399);
      endcase
    end else if (kind < 90) begin
      yr = $urandom_range(2106, 1970);
      days = 0;
      for (int y = 1970; y < yr; y++)
        days += ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 366 : 365;
      days += day_picks[$urandom_range(4)];
      t = days * 86400 + ($urandom_range(1) ? 86399 : 0) - {{15{zone_now[16]}}, zone_now};
    end else begin
      t = $urandom_range(1) ? 32'($urandom_range(200000))
                            : 32'hFFFFFFFF - $urandom_range(200000);
    end
    return t;
  endfunction

  // one request, with random idle cycles ahead of it
  task automatic send_request(input logic [31:0] t, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_epoch_seconds <= t;
    do @(posedge clk); while (busy);
  endtask

  // stop sending and let every pending result come out
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  task automatic write_zone(input logic [16:0] offset);
    cfg_we <= 1'b1;
    cfg_wdata <= offset;
    zone_now = offset;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset offset: edge cases, then random
    foreach (EDGE_TIMES[i])
      send_request(EDGE_TIMES[i], 0);
    repeat (PHASE_ITEMS) send_request(pick_epoch(), 0);
    drain();

    // one phase per zone setting, last one random
    for (int p = 1; p <= 6; p++) begin
      if (p <= 5)
        write_zone(ZONE_SETTINGS[p - 1]);
      else
        write_zone(17'($urandom_range(100800) - 50400));
      repeat (PHASE_ITEMS) send_request(pick_epoch(), IDLE_PCT[p % 3]);
      drain();
    end

    if (errors == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### epoch_to_calendar_date.f
rtl/core/ecd_pkg.sv
rtl/core/epoch_to_calendar_date.sv
test/calendar_date_checker.sv
test/tb.sv
